// ----- rtl/spso_pkg.sv -----
package spso_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SCAN_STYLE = 2'd2;

  localparam int DimW = 9;
  localparam int CoordW = 8;
  localparam int StyleW = 4;
  localparam int IndexW = 9;

  // scan style codes
  localparam logic [StyleW-1:0] STYLE_HOLD = 4'd0;
  localparam logic [StyleW-1:0] STYLE_COL_TL = 4'd1;
  localparam logic [StyleW-1:0] STYLE_ROW_TL = 4'd2;
  localparam logic [StyleW-1:0] STYLE_COL_TR = 4'd3;
  localparam logic [StyleW-1:0] STYLE_ROW_TR = 4'd4;
  localparam logic [StyleW-1:0] STYLE_COL_BL = 4'd5;
  localparam logic [StyleW-1:0] STYLE_ROW_BL = 4'd6;
  localparam logic [StyleW-1:0] STYLE_COL_BR = 4'd7;
  localparam logic [StyleW-1:0] STYLE_ROW_BR = 4'd8;

  // decoded grid geometry and style
  typedef struct packed {
    logic [CoordW-1:0] row_max;
    logic [CoordW-1:0] col_max;
    logic              active;
    logic              from_right;
    logic              from_bottom;
    logic              col_major;
  } spso_geom_t;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } spso_pos_t;

endpackage

// ----- rtl/spso_if.sv -----
interface spso_in_if;
  import spso_pkg::*;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface spso_out_if;
  import spso_pkg::*;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] col;
  logic [CoordW-1:0] row;
  logic [IndexW-1:0] chain_index;
  logic              last;
  modport source (output valid, output col, output row, output chain_index, output last,
                  input ready);
  modport sink (input valid, input col, input row, input chain_index, input last,
                output ready);
endinterface

// ----- rtl/spso_cfg.sv -----
module spso_cfg
  import spso_pkg::*;
#(
  parameter int MAX_CARDS = 256,
  localparam int CntW = $clog2(MAX_CARDS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output spso_geom_t          geom,
  output logic [CntW-1:0]     total
);

  localparam logic [2*DimW-1:0] MaxCards = (2*DimW)'(MAX_CARDS);

  logic [DimW-1:0]   row_count;
  logic [DimW-1:0]   col_count;
  logic [StyleW-1:0] scan_style;
  logic [2*DimW-1:0] grid_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= DimW'(1);
      col_count  <= DimW'(1);
      scan_style <= STYLE_COL_TL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:  row_count <= cfg_data;
        REG_COL_COUNT:  col_count <= cfg_data;
        REG_SCAN_STYLE: scan_style <= cfg_data[StyleW-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, anything past 256 as 256
  function automatic logic [CoordW-1:0] dim_max(input logic [DimW-1:0] v);
    logic [CoordW-1:0] m;
    if (v == '0) m = '0;
    else if (v[DimW-1]) m = '1;
    else m = v[CoordW-1:0] - CoordW'(1);
    return m;
  endfunction

  always_comb begin
    geom.row_max     = dim_max(row_count);
    geom.col_max     = dim_max(col_count);
    geom.active      = 1'b1;
    geom.from_right  = 1'b0;
    geom.from_bottom = 1'b0;
    geom.col_major   = scan_style[0];
    unique case (scan_style)
      STYLE_COL_TL, STYLE_ROW_TL: ;
      STYLE_COL_TR, STYLE_ROW_TR: geom.from_right = 1'b1;
      STYLE_COL_BL, STYLE_ROW_BL: geom.from_bottom = 1'b1;
      STYLE_COL_BR, STYLE_ROW_BR: begin
        geom.from_right  = 1'b1;
        geom.from_bottom = 1'b1;
      end
      default: geom.active = 1'b0;
    endcase
  end

  assign grid_size = (2*DimW)'({1'b0, geom.row_max} + DimW'(1))
                   * (2*DimW)'({1'b0, geom.col_max} + DimW'(1));
  assign total = (grid_size > MaxCards) ? CntW'(MaxCards) : CntW'(grid_size);

endmodule

// ----- rtl/spso_step.sv -----
module spso_step
  import spso_pkg::*;
(
  input  spso_geom_t geom,
  input  logic       load,
  input  spso_pos_t  cur,
  output spso_pos_t  nxt
);

  logic parity;
  logic inc;

  always_comb begin
    nxt    = cur;
    parity = 1'b0;
    inc    = 1'b0;
    if (load) begin
      nxt.col = (geom.active && geom.from_right) ? geom.col_max : '0;
      nxt.row = (geom.active && geom.from_bottom) ? geom.row_max : '0;
    end else if (geom.active) begin
      if (geom.col_major) begin
        // column parity relative to the start column
        parity = cur.col[0] ^ (geom.from_right & geom.col_max[0]);
        inc    = !parity ^ geom.from_bottom;
        if (inc && cur.row < geom.row_max) nxt.row = cur.row + CoordW'(1);
        else if (!inc && cur.row != '0) nxt.row = cur.row - CoordW'(1);
        else nxt.col = geom.from_right ? cur.col - CoordW'(1) : cur.col + CoordW'(1);
      end else begin
        parity = cur.row[0] ^ (geom.from_bottom & geom.row_max[0]);
        inc    = !parity ^ geom.from_right;
        if (inc && cur.col < geom.col_max) nxt.col = cur.col + CoordW'(1);
        else if (!inc && cur.col != '0) nxt.col = cur.col - CoordW'(1);
        else nxt.row = geom.from_bottom ? cur.row - CoordW'(1) : cur.row + CoordW'(1);
      end
    end
  end

endmodule

// ----- rtl/serpentine_panel_scan_order.sv -----
// Serpentine panel scan order: every input transfer yields exactly one output transfer with
// the column, row, 1-based chain index and last flag of the next panel in a daisy chain over
// a row_count by col_count grid. A transfer with restart set, the first after reset, or the
// first after the last panel of a run loads the start corner of scan_style; any other takes
// one snake step. Styles 1..8 pick major axis (odd column-major, even row-major) and start
// corner; style 0 and codes above 8 hold at (0,0) while the index still counts. A run is
// min(rows*cols, MAX_CARDS) long. Throughput is one item per clock while scan_out is ready: the
// position registers double as the output register, so an item transfers in while the previous
// result is being taken, and a result appears in the cycle after its input transfer. Write the
// configuration only while no result is pending.
module serpentine_panel_scan_order
  import spso_pkg::*;
#(
  parameter int MAX_CARDS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  spso_in_if.sink             scan_in,
  spso_out_if.source          scan_out
);

  localparam int CntW = $clog2(MAX_CARDS + 1);

  spso_geom_t      geom;
  logic [CntW-1:0] total;

  // current position and count, also the output register
  spso_pos_t       cur;
  spso_pos_t       cur_next;
  logic [CntW-1:0] step_count;
  logic [CntW-1:0] step_count_next;
  logic            last;
  logic            out_valid;

  logic            in_xfer;
  logic            load;
  logic [31:0]     count_wide;

  spso_cfg #(.MAX_CARDS(MAX_CARDS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .total     (total)
  );

  // new run on request, when no run is open, or once the run is used up
  assign load = scan_in.restart || (step_count == '0) || (step_count >= total);

  spso_step u_step (
    .geom (geom),
    .load (load),
    .cur  (cur),
    .nxt  (cur_next)
  );

  assign step_count_next = load ? CntW'(1) : step_count + CntW'(1);

  // take a new item whenever the result slot is empty or draining this clock
  assign scan_in.ready = !out_valid || scan_out.ready;
  assign in_xfer       = scan_in.valid && scan_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      step_count <= '0;
      out_valid  <= 1'b0;
      last       <= 1'b0;
    end else if (in_xfer) begin
      cur        <= cur_next;
      step_count <= step_count_next;
      last       <= (step_count_next == total);
      out_valid  <= 1'b1;
    end else if (scan_out.ready) begin
      out_valid  <= 1'b0;
    end
  end

  // chain index is the low bits of the count
  assign count_wide = 32'(step_count);

  assign scan_out.valid       = out_valid;
  assign scan_out.col         = cur.col;
  assign scan_out.row         = cur.row;
  assign scan_out.chain_index = count_wide[IndexW-1:0];
  assign scan_out.last        = last;

  // an accepted item always opens or extends a run
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (step_count != '0) && out_valid)
    else $error("count zero after accepted item");

  // restart always lands on the first chain position
  a_restart_first: assert property (@(posedge clk) disable iff (rst)
    in_xfer && scan_in.restart |=> step_count == CntW'(1))
    else $error("restart did not reload the run");

  // the count never passes the run length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !load |-> step_count < total)
    else $error("step taken past end of run");

  // an empty result slot never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> scan_in.ready)
    else $error("input stalled with empty output");

endmodule

// ----- verif/spso_tb_pkg.sv -----
package spso_tb_pkg;
  import spso_pkg::*;

  localparam int PanelLimit = 256;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [IndexW-1:0] chain_index;
    logic              last;
  } panel_slot_t;

  class panel_order_checker;
    int unsigned       rows_reg;
    int unsigned       cols_reg;
    logic [StyleW-1:0] style_reg;
    int unsigned       pos_col;
    int unsigned       pos_row;
    int unsigned       run_pos;
    panel_slot_t       expected_panels[$];
    int unsigned       errors;

    function new();
      rows_reg  = 1;
      cols_reg  = 1;
      style_reg = STYLE_COL_TL;
      pos_col   = 0;
      pos_row   = 0;
      run_pos   = 0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_ROW_COUNT:  rows_reg = data;
        REG_COL_COUNT:  cols_reg = data;
        REG_SCAN_STYLE: style_reg = data[StyleW-1:0];
        default: ;
      endcase
    endfunction

    // zero counts as one, anything past 256 as 256
    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
    endfunction

    // next panel position for one accepted step request
    function void note_input(bit restart);
      int unsigned r, c, span, x0, y0;
      bit          active, right, bottom, by_col, up;
      panel_slot_t slot;
      r = clamp_dim(rows_reg);
      c = clamp_dim(cols_reg);
      span = (r * c > PanelLimit) ? PanelLimit : r * c;
      active = 1'b1;
      right  = 1'b0;
      bottom = 1'b0;
      case (style_reg)
        STYLE_COL_TL, STYLE_ROW_TL: ;
        STYLE_COL_TR, STYLE_ROW_TR: right = 1'b1;
        STYLE_COL_BL, STYLE_ROW_BL: bottom = 1'b1;
        STYLE_COL_BR, STYLE_ROW_BR: begin
          right  = 1'b1;
          bottom = 1'b1;
        end
        default: active = 1'b0;
      endcase
      by_col = style_reg[0];
      if (restart || run_pos == 0 || run_pos >= span) begin
        pos_col = (active && right) ? c - 1 : 0;
        pos_row = (active && bottom) ? r - 1 : 0;
        run_pos = 1;
      end else begin
        if (active) begin
          x0 = right ? c - 1 : 0;
          y0 = bottom ? r - 1 : 0;
          if (by_col) begin
            // parity relative to the start column
            up = ((((pos_col ^ x0) & 1) == 0) != bottom);
            if (up && pos_row < r - 1) pos_row = pos_row + 1;
            else if (!up && pos_row > 0) pos_row = pos_row - 1;
            else pos_col = (right ? pos_col - 1 : pos_col + 1) & 'hFF;
          end else begin
            up = ((((pos_row ^ y0) & 1) == 0) != right);
            if (up && pos_col < c - 1) pos_col = pos_col + 1;
            else if (!up && pos_col > 0) pos_col = pos_col - 1;
            else pos_row = (bottom ? pos_row - 1 : pos_row + 1) & 'hFF;
          end
        end
        run_pos = run_pos + 1;
      end
      slot.col         = CoordW'(pos_col);
      slot.row         = CoordW'(pos_row);
      slot.chain_index = IndexW'(run_pos);
      slot.last        = (run_pos == span);
      expected_panels.push_back(slot);
    endfunction

    function int pending();
      return expected_panels.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(panel_slot_t got);
      panel_slot_t want;
      if (expected_panels.size() == 0) begin
        report_mismatch($sformatf("unexpected result col %0d row %0d index %0d",
                                  got.col, got.row, got.chain_index));
        return;
      end
      want = expected_panels.pop_front();
      if (got.col !== want.col)
        report_mismatch($sformatf("index %0d: col %0d, expected %0d",
                                  want.chain_index, got.col, want.col));
      if (got.row !== want.row)
        report_mismatch($sformatf("index %0d: row %0d, expected %0d",
                                  want.chain_index, got.row, want.row));
      if (got.chain_index !== want.chain_index)
        report_mismatch($sformatf("chain_index %0d, expected %0d",
                                  got.chain_index, want.chain_index));
      if (got.last !== want.last)
        report_mismatch($sformatf("index %0d: last %0b, expected %0b",
                                  want.chain_index, got.last, want.last));
    endtask

    task drop_leftovers();
      if (expected_panels.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_panels.size()));
      expected_panels.delete();
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spso_pkg::*;
  import spso_tb_pkg::*;

  localparam int ClkPeriod = 20;
  localparam int RandomItems = 1350;
  localparam int QuietTail = 150;    // final stretch with no idling on either side
  localparam int LongHold = 300;     // receiver hold-off that backs up the input
  localparam int DrainLimit = 5000;
  // index with no register behind it, and a style code past the defined ones
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
  localparam logic [StyleW-1:0] STYLE_SPARE = 4'd15;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  spso_in_if  scan_in_ch ();
  spso_out_if scan_out_ch ();

  panel_order_checker board = new();

  int unsigned items_sent;
  int unsigned restarts_sent;
  int unsigned runs_closed;
  int unsigned reg_writes;
  bit          idle_on;
  bit          hold_request;
  bit          hold_done;
  int          sink_stall;

  always #(ClkPeriod / 2) clk = ~clk;

  serpentine_panel_scan_order #(.MAX_CARDS(PanelLimit)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scan_in   (scan_in_ch),
    .scan_out  (scan_out_ch)
  );

  // monitor: note accepted requests first, then check the result transfer of this edge
  always @(posedge clk) begin
    panel_slot_t got;
    if (!rst) begin
      if (scan_in_ch.valid && scan_in_ch.ready) board.note_input(scan_in_ch.restart);
      if (scan_out_ch.valid && scan_out_ch.ready) begin
        got.col         = scan_out_ch.col;
        got.row         = scan_out_ch.row;
        got.chain_index = scan_out_ch.chain_index;
        got.last        = scan_out_ch.last;
        board.check_result(got);
        if (got.last === 1'b1) runs_closed++;
      end
    end
  end

  // receiver: one ready update per edge, short random stalls, one long hold on request
  initial begin
    scan_out_ch.ready <= 1'b0;
    sink_stall = 0;
    forever begin
      @(posedge clk);
      if (sink_stall > 0) begin
        sink_stall--;
        scan_out_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        sink_stall = LongHold - 1;
        scan_out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(1, 15) - 1;
        scan_out_ch.ready <= 1'b0;
      end else begin
        scan_out_ch.ready <= 1'b1;
      end
    end
  end

  // one step request, held until the transfer, then maybe a gap
  task automatic push_item(bit rs);
    scan_in_ch.valid   <= 1'b1;
    scan_in_ch.restart <= rs;
    do @(posedge clk); while (!scan_in_ch.ready);
    items_sent++;
    if (rs) restarts_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      scan_in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every expected position has come back
  task automatic quiesce();
    int guard;
    guard = 0;
    scan_in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0 && guard < DrainLimit) begin
      @(posedge clk);
      guard++;
    end
    board.drop_leftovers();
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(val);
    @(posedge clk);
    board.set_reg(idx, CfgDataW'(val));
    reg_writes++;
  endtask

  task automatic configure(int unsigned rows, int unsigned cols, logic [StyleW-1:0] style);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_SCAN_STYLE, style);
    cfg_we <= 1'b0;
  endtask

  // mostly small grids so runs close often, sometimes the clamp extremes or a big one
  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 511;
      2: return 256;
      3: return $urandom_range(7, 511);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [StyleW-1:0] pick_style();
    int unsigned x;
    x = $urandom_range(0, 19);
    if (x < 16) return StyleW'(1 + x % 8);
    if (x == 16) return STYLE_HOLD;
    return StyleW'($urandom_range(9, 15));
  endfunction

  initial begin
    int unsigned      n, rows, cols, target;
    logic [StyleW-1:0] style;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_ROW_COUNT;
    cfg_data           <= '0;
    scan_in_ch.valid   <= 1'b0;
    scan_in_ch.restart <= 1'b0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    rows = 1;
    cols = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset geometry is 1x1: first item loads, second one overruns and reloads
    push_item(1'b0);
    push_item(1'b0);

    // 2x3 row-major from top right, restart mid-run, then a full run and wrap
    quiesce();
    configure(2, 3, STYLE_ROW_TR);
    push_item(1'b0);
    push_item(1'b0);
    push_item(1'b1);
    repeat (6) push_item(1'b0);

    // zero rows clamps to one, 511 columns clamps to 256
    quiesce();
    configure(0, 511, STYLE_COL_TR);
    push_item(1'b0);
    push_item(1'b0);

    // hold style and an undefined style both sit at the origin
    quiesce();
    configure(3, 3, STYLE_HOLD);
    push_item(1'b0);
    push_item(1'b0);
    quiesce();
    write_reg(REG_SCAN_STYLE, STYLE_SPARE);
    cfg_we <= 1'b0;
    push_item(1'b0);
    push_item(1'b1);

    // largest grid, start at the far corner
    quiesce();
    configure(256, 256, STYLE_ROW_BR);
    push_item(1'b0);
    push_item(1'b0);

    // write to an unmapped index, then shrink mid-run so the count overruns
    quiesce();
    write_reg(REG_SPARE, 'h1FF);
    write_reg(REG_ROW_COUNT, 1);
    write_reg(REG_COL_COUNT, 1);
    cfg_we <= 1'b0;
    push_item(1'b0);

    // style switch in the middle of a run
    quiesce();
    configure(4, 4, STYLE_COL_BL);
    repeat (3) push_item(1'b0);
    quiesce();
    write_reg(REG_SCAN_STYLE, STYLE_ROW_TL);
    cfg_we <= 1'b0;
    push_item(1'b0);
    push_item(1'b0);

    // random phases; config changes between phases often land mid-run
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      quiesce();
      if ($urandom_range(0, 3) != 0) begin
        rows = pick_dim();
        cols = pick_dim();
      end
      style = pick_style();
      configure(rows, cols, style);
      idle_on = (target - items_sent > QuietTail) && ($urandom_range(0, 4) != 0);
      // one long receiver hold-off with the sender offering back to back
      if (!hold_done && items_sent > target / 2) begin
        hold_done    = 1'b1;
        idle_on      = 1'b0;
        hold_request = 1'b1;
      end
      n = $urandom_range(20, 90);
      repeat (n) push_item($urandom_range(0, 15) == 0);
    end
    idle_on = 1'b0;
    quiesce();

    $display("covered %0d step transfers (%0d restarts), %0d register writes, %0d runs closed",
             items_sent, restarts_sent, reg_writes, runs_closed);
    $display("styles 0..15, clamped and shrunk grids, mid-run changes, long output hold-off");
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // safety net well past the slowest legal run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/spso_pkg.sv
rtl/spso_if.sv
rtl/spso_cfg.sv
rtl/spso_step.sv
rtl/serpentine_panel_scan_order.sv
verif/spso_tb_pkg.sv
verif/tb_top.sv
